[hdl/dcwc_pkg.sv]
// ----------------------------------------------------------------------------
// dcwc_pkg
// Shared types, constants and register codes for the defect candidate
// window classifier.
// ----------------------------------------------------------------------------
package dcwc_pkg;

  localparam int FEAT_W     = 16;
  localparam int WIN_W      = 32;
  localparam int THR_W      = 4;
  localparam int NUM_WIN    = 7;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int TALLY_W    = 16;

  // Ratio divider: dividend 20*outer+inner, divisor 2*inner
  localparam int DVD_W      = 21;
  localparam int DVS_W      = 17;
  localparam int REM_W      = DVS_W + 1;
  localparam int DIV_STEPS  = DVD_W;
  localparam int STEP_W     = 5;

  localparam logic [FEAT_W-1:0]  RATIO_SAT = '1;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GREY_GAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVELOPED = 3'd7;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0] THRESHOLD_RST = 4'd7;
  localparam logic [WIN_W-1:0] WIN_RST [NUM_WIN] = '{
    {16'd400,  16'd200},
    {16'd35,   16'd5},
    {16'd250,  16'd80},
    {16'd120,  16'd70},
    {16'd25,   16'd15},
    {16'd35,   16'd25},
    {16'd1000, 16'd500}
  };

  typedef struct packed {
    logic [FEAT_W-1:0] seam_length;
    logic [FEAT_W-1:0] seam_width;
    logic [FEAT_W-1:0] edge_gradient;
    logic [FEAT_W-1:0] grey_gap;
    logic [FEAT_W-1:0] grey_inner;
    logic [FEAT_W-1:0] grey_outer;
    logic [FEAT_W-1:0] deviation;
    logic [FEAT_W-1:0] developed_left;
    logic [FEAT_W-1:0] developed_right;
    logic              last_in_image;
  } dcwc_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL
  } dcwc_state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } dcwc_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic div_done;
    logic out_free;
  } dcwc_sts_t;

endpackage

[hdl/dcwc_in_if.sv]
// ----------------------------------------------------------------------------
// dcwc_in_if
// Candidate input channel: valid/ready handshake with feature payload.
// ----------------------------------------------------------------------------
interface dcwc_in_if;
  logic                        valid;
  logic                        ready;
  logic [dcwc_pkg::FEAT_W-1:0] seam_length;
  logic [dcwc_pkg::FEAT_W-1:0] seam_width;
  logic [dcwc_pkg::FEAT_W-1:0] edge_gradient;
  logic [dcwc_pkg::FEAT_W-1:0] grey_gap;
  logic [dcwc_pkg::FEAT_W-1:0] grey_inner;
  logic [dcwc_pkg::FEAT_W-1:0] grey_outer;
  logic [dcwc_pkg::FEAT_W-1:0] deviation;
  logic [dcwc_pkg::FEAT_W-1:0] developed_left;
  logic [dcwc_pkg::FEAT_W-1:0] developed_right;
  logic                        last_in_image;

  modport source (
    output valid, seam_length, seam_width, edge_gradient, grey_gap, grey_inner,
           grey_outer, deviation, developed_left, developed_right, last_in_image,
    input  ready
  );

  modport sink (
    input  valid, seam_length, seam_width, edge_gradient, grey_gap, grey_inner,
           grey_outer, deviation, developed_left, developed_right, last_in_image,
    output ready
  );
endinterface

[hdl/dcwc_out_if.sv]
// ----------------------------------------------------------------------------
// dcwc_out_if
// Classification result channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface dcwc_out_if;
  logic                         valid;
  logic                         ready;
  logic [dcwc_pkg::CNT_W-1:0]   match_count;
  logic [dcwc_pkg::CNT_W-1:0]   first_failed;
  logic                         is_flagged;
  logic [dcwc_pkg::TALLY_W-1:0] flagged_total;
  logic                         image_done;

  modport source (
    output valid, match_count, first_failed, is_flagged, flagged_total, image_done,
    input  ready
  );

  modport sink (
    input  valid, match_count, first_failed, is_flagged, flagged_total, image_done,
    output ready
  );
endinterface

[hdl/dcwc_divider.sv]
// ----------------------------------------------------------------------------
// dcwc_divider
// Restoring radix-2 divider, one quotient bit per cycle, for the grey ratio.
// ----------------------------------------------------------------------------
module dcwc_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dcwc_pkg::DVD_W-1:0]   dividend,
  input  logic [dcwc_pkg::DVS_W-1:0]   divisor,
  output logic                         done,
  output logic [dcwc_pkg::DVD_W-1:0]   quotient
);
  import dcwc_pkg::*;

  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [DVD_W-1:0]  quo_r,  quo_nxt;
  logic [DVS_W-1:0]  dvs_r,  dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W:0]    diff;

  // Shift in next dividend bit and trial-subtract the divisor
  always_comb begin
    rem_sh = {rem_r[REM_W-2:0], quo_r[DVD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[REM_W]) begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[REM_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold datapath registers, reset only the control bits
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

[hdl/dcwc_datapath.sv]
// ----------------------------------------------------------------------------
// dcwc_datapath
// Configuration registers, candidate register, ratio divider, window checks,
// flag tally and output register.
// ----------------------------------------------------------------------------
module dcwc_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dcwc_pkg::dcwc_cmd_t              cmd,
  output dcwc_pkg::dcwc_sts_t              sts,
  input  logic                             in_valid,
  input  dcwc_pkg::dcwc_item_t             in_item,
  input  logic                             cfg_we,
  input  logic [dcwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcwc_pkg::WIN_W-1:0]       cfg_wdata,
  dcwc_out_if.source                       out_ch
);
  import dcwc_pkg::*;

  logic [THR_W-1:0]   thr_r;
  logic [WIN_W-1:0]   win_r [NUM_WIN];
  dcwc_item_t         item_r;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               oval_r, oval_nxt;

  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   first_r;
  logic               flag_r;
  logic [TALLY_W-1:0] total_r;
  logic               done_r;

  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic               div_done;
  logic [DVD_W-1:0]   quo;

  logic [FEAT_W-1:0]  ratio;
  logic [FEAT_W:0]    dev_sum;
  logic [FEAT_W-1:0]  feat [NUM_WIN];
  logic [NUM_WIN-1:0] hit;
  logic [CNT_W-1:0]   match_cnt;
  logic [CNT_W-1:0]   first_fail;
  logic               flagged;
  logic [TALLY_W-1:0] tally_inc;

  // Ratio divider operands: 20*outer + inner over 2*inner
  assign dvd = {1'b0, in_item.grey_outer, 4'b0000}
             + {3'b000, in_item.grey_outer, 2'b00}
             + {5'b00000, in_item.grey_inner};
  assign dvs = {in_item.grey_inner, 1'b0};

  dcwc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RST;
      for (int i = 0; i < NUM_WIN; i++) begin
        win_r[i] <= WIN_RST[i];
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
        default:       win_r[CFG_IDX_W'(cfg_index - 1'b1)] <= cfg_wdata;
      endcase
    end
  end

  // Capture the candidate on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  // Build features: saturated ratio and mean developed length
  always_comb begin
    if (item_r.grey_inner == '0) begin
      ratio = '0;
    end else if (|quo[DVD_W-1:FEAT_W]) begin
      ratio = RATIO_SAT;
    end else begin
      ratio = quo[FEAT_W-1:0];
    end
    dev_sum = {1'b0, item_r.developed_left} + {1'b0, item_r.developed_right};
    feat[0] = item_r.seam_length;
    feat[1] = item_r.seam_width;
    feat[2] = item_r.edge_gradient;
    feat[3] = item_r.grey_gap;
    feat[4] = ratio;
    feat[5] = item_r.deviation;
    feat[6] = dev_sum[FEAT_W:1];
  end

  // Check windows, count hits and find the first miss
  always_comb begin
    match_cnt  = '0;
    first_fail = '0;
    for (int i = 0; i < NUM_WIN; i++) begin
      hit[i] = (feat[i] >= win_r[i][FEAT_W-1:0])
            && (feat[i] <= win_r[i][WIN_W-1:FEAT_W]);
      match_cnt = match_cnt + CNT_W'(hit[i]);
    end
    for (int i = NUM_WIN - 1; i >= 0; i--) begin
      if (!hit[i]) begin
        first_fail = CNT_W'(i + 1);
      end
    end
    flagged   = ({1'b0, match_cnt} >= thr_r);
    tally_inc = (flagged && tally_r != TALLY_MAX) ? tally_r + 1'b1 : tally_r;
  end

  // Advance tally and output valid
  always_comb begin
    tally_nxt = tally_r;
    oval_nxt  = oval_r;
    if (cmd.commit) begin
      tally_nxt = item_r.last_in_image ? '0 : tally_inc;
      oval_nxt  = 1'b1;
    end else if (out_ch.ready) begin
      oval_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      tally_r <= tally_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cnt_r   <= match_cnt;
      first_r <= first_fail;
      flag_r  <= flagged;
      total_r <= tally_inc;
      done_r  <= item_r.last_in_image;
    end
  end

  assign out_ch.valid         = oval_r;
  assign out_ch.match_count   = cnt_r;
  assign out_ch.first_failed  = first_r;
  assign out_ch.is_flagged    = flag_r;
  assign out_ch.flagged_total = total_r;
  assign out_ch.image_done    = done_r;

  assign sts.in_valid = in_valid;
  assign sts.div_done = div_done;
  assign sts.out_free = !oval_r || out_ch.ready;
endmodule

[hdl/dcwc_ctrl.sv]
// ----------------------------------------------------------------------------
// dcwc_ctrl
// Sequencer: accept a candidate, wait for the ratio division, commit the
// result beat into the output register.
// ----------------------------------------------------------------------------
module dcwc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  dcwc_pkg::dcwc_sts_t sts,
  output dcwc_pkg::dcwc_cmd_t cmd,
  output logic                in_ready
);
  import dcwc_pkg::*;

  dcwc_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (sts.in_valid) state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_done) state_nxt = ST_EVAL;
      ST_EVAL: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = sts.in_valid;
      end
      ST_EVAL: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

[hdl/defect_candidate_window_classifier_unit.sv]
// ----------------------------------------------------------------------------
// defect_candidate_window_classifier_unit
// Classifies weld-seam defect candidates against seven feature windows and
// keeps a per-image count of flagged candidates.
// ----------------------------------------------------------------------------
// Result path: an accepted beat starts the 21-step radix-2 ratio divider; when it
//   is done the controller commits the result beat into the output register,
//   waiting while the previous result is not taken. A new candidate is accepted
//   only after that commit, once the controller is back in idle.
// A finished result waits in the output register while the next beat is taken.
// Reset: synchronous, active low; restores default windows and threshold 7,
//   clears the flag tally and the output valid.
// ----------------------------------------------------------------------------
module defect_candidate_window_classifier_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  dcwc_in_if.sink                         in_ch,
  dcwc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dcwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcwc_pkg::WIN_W-1:0]      cfg_wdata
);
  import dcwc_pkg::*;

  dcwc_cmd_t  cmd;
  dcwc_sts_t  sts;
  dcwc_item_t in_item;
  logic       in_ready;

  // Pack the input beat
  assign in_item.seam_length     = in_ch.seam_length;
  assign in_item.seam_width      = in_ch.seam_width;
  assign in_item.edge_gradient   = in_ch.edge_gradient;
  assign in_item.grey_gap        = in_ch.grey_gap;
  assign in_item.grey_inner      = in_ch.grey_inner;
  assign in_item.grey_outer      = in_ch.grey_outer;
  assign in_item.deviation       = in_ch.deviation;
  assign in_item.developed_left  = in_ch.developed_left;
  assign in_item.developed_right = in_ch.developed_right;
  assign in_item.last_in_image   = in_ch.last_in_image;
  assign in_ch.ready             = in_ready;

  dcwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  dcwc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_ch.valid),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );
endmodule
